// ===== hw/rtl/bswq_pkg.sv =====
// Shared types, constants and the microcode program of the bounded stack core.
// No dependencies; every other file of the block but bswq_ram refers to this package.
`timescale 1ns / 1ps

package bswq_pkg;

   // Defaults for the top-level parameters and the fixed field widths.
   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int OP_W           = 3;
   localparam int WORD_W         = 32;
   localparam int CAP_W          = 5;
   localparam int HEIGHT_W       = 5;
   localparam int STATUS_W       = 2;
   localparam int RSP_DATA_W     = 40;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH, OP_POP, OP_PEEK, OP_STATUS, OP_SUM, OP_PRODUCT, OP_CONTAINS, OP_DUMP
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK, ST_FULL, ST_EMPTY
   } status_type;

   // Microcode addresses. The full and empty tests fall through to the next address.
   typedef enum logic [4:0] {
      U_FETCH, U_PUSH, U_PUSH_WR, U_POP, U_POP_RD, U_PEEK, U_PEEK_RD, U_EMIT_RD,
      U_SUM, U_SUM_LOOP, U_PROD, U_PROD_LOOP, U_CONT, U_CONT_LOOP, U_DUMP,
      U_DUMP_LOOP, U_EMIT_ACC, U_EMIT_OK, U_EMIT_FULL, U_EMIT_EMPTY
   } upc_type;

   typedef enum logic [2:0] {
      SEQ_JUMP, SEQ_DISPATCH, SEQ_IF_FULL, SEQ_IF_EMPTY, SEQ_LOOP
   } seq_type;

   typedef enum logic [1:0] {IDX_HOLD, IDX_ZERO, IDX_TOP} idx_type;
   typedef enum logic {DIR_UP, DIR_DOWN} dir_type;
   typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_type;
   typedef enum logic [2:0] {
      ACC_NONE, ACC_ZERO, ACC_ONE, ACC_ADD, ACC_MUL, ACC_CMP
   } acc_type;
   typedef enum logic [1:0] {EMIT_NONE, EMIT_ALWAYS, EMIT_RVALID} emit_type;
   typedef enum logic [1:0] {DSEL_ZERO, DSEL_RDATA, DSEL_ACC} dsel_type;
   typedef enum logic {LAST_ONE, LAST_IDX0} last_type;

   // One control word of the program.
   typedef struct packed {
      logic       take;
      seq_type    seq;
      upc_type    target;
      idx_type    idx;
      logic       walk;
      dir_type    dir;
      logic       rd_top;
      logic       wr_push;
      cnt_type    cnt;
      acc_type    acc;
      emit_type   emit;
      status_type st;
      dsel_type   dsel;
      last_type   last;
   } ctrl_type;

   // Sequencer to datapath.
   typedef struct packed {
      ctrl_type word;
      logic     accept;
   } cmd_type;

   // Datapath to sequencer.
   typedef struct packed {
      logic full;
      logic empty;
      logic more;
      logic stall;
   } flags_type;

   // Entry point of each operation.
   function automatic upc_type dispatch(input op_type op);
      upc_type u;
      case (op)
         OP_PUSH:     u = U_PUSH;
         OP_POP:      u = U_POP;
         OP_PEEK:     u = U_PEEK;
         OP_STATUS:   u = U_EMIT_OK;
         OP_SUM:      u = U_SUM;
         OP_PRODUCT:  u = U_PROD;
         OP_CONTAINS: u = U_CONT;
         OP_DUMP:     u = U_DUMP;
         default:     u = U_EMIT_OK;
      endcase
      return u;
   endfunction

   // The control store.
   function automatic ctrl_type ucode_rom(input upc_type upc);
      ctrl_type w;
      w = '0;
      w.seq    = SEQ_JUMP;
      w.target = U_FETCH;
      case (upc)
         U_FETCH: begin
            w.take = 1'b1;
            w.seq  = SEQ_DISPATCH;
         end
         U_PUSH: begin
            w.seq    = SEQ_IF_FULL;
            w.target = U_EMIT_FULL;
         end
         U_PUSH_WR: begin
            w.wr_push = 1'b1;
            w.cnt     = CNT_INC;
            w.target  = U_EMIT_OK;
         end
         U_POP, U_PEEK: begin
            w.seq    = SEQ_IF_EMPTY;
            w.target = U_EMIT_EMPTY;
         end
         U_POP_RD: begin
            w.rd_top = 1'b1;
            w.cnt    = CNT_DEC;
            w.target = U_EMIT_RD;
         end
         U_PEEK_RD: begin
            w.rd_top = 1'b1;
            w.target = U_EMIT_RD;
         end
         U_EMIT_RD: begin
            w.emit = EMIT_ALWAYS;
            w.dsel = DSEL_RDATA;
         end
         U_SUM: begin
            w.seq    = SEQ_IF_EMPTY;
            w.target = U_EMIT_EMPTY;
            w.idx    = IDX_ZERO;
            w.acc    = ACC_ZERO;
         end
         U_SUM_LOOP: begin
            w.walk   = 1'b1;
            w.acc    = ACC_ADD;
            w.seq    = SEQ_LOOP;
            w.target = U_EMIT_ACC;
         end
         U_PROD: begin
            w.seq    = SEQ_IF_EMPTY;
            w.target = U_EMIT_EMPTY;
            w.idx    = IDX_ZERO;
            w.acc    = ACC_ONE;
         end
         U_PROD_LOOP: begin
            w.walk   = 1'b1;
            w.acc    = ACC_MUL;
            w.seq    = SEQ_LOOP;
            w.target = U_EMIT_ACC;
         end
         U_CONT: begin
            w.seq    = SEQ_IF_EMPTY;
            w.target = U_EMIT_EMPTY;
            w.idx    = IDX_ZERO;
         end
         U_CONT_LOOP: begin
            w.walk   = 1'b1;
            w.acc    = ACC_CMP;
            w.seq    = SEQ_LOOP;
            w.target = U_EMIT_OK;
         end
         U_DUMP: begin
            w.seq    = SEQ_IF_EMPTY;
            w.target = U_EMIT_EMPTY;
            w.idx    = IDX_TOP;
         end
         U_DUMP_LOOP: begin
            w.walk   = 1'b1;
            w.dir    = DIR_DOWN;
            w.emit   = EMIT_RVALID;
            w.dsel   = DSEL_RDATA;
            w.last   = LAST_IDX0;
            w.seq    = SEQ_LOOP;
            w.target = U_FETCH;
         end
         U_EMIT_ACC: begin
            w.emit = EMIT_ALWAYS;
            w.dsel = DSEL_ACC;
         end
         U_EMIT_OK: begin
            w.emit = EMIT_ALWAYS;
         end
         U_EMIT_FULL: begin
            w.emit = EMIT_ALWAYS;
            w.st   = ST_FULL;
         end
         U_EMIT_EMPTY: begin
            w.emit = EMIT_ALWAYS;
            w.st   = ST_EMPTY;
         end
         default: begin
            w.target = U_FETCH;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/bswq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bswq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/bswq_seq.sv =====
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on bswq_pkg.
`timescale 1ns / 1ps

module bswq_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [bswq_pkg::OP_W-1:0] req_op,
   output logic                    req_ready,
   input  bswq_pkg::flags_type     flags,
   output bswq_pkg::cmd_type       cmd
);

   bswq_pkg::upc_type  upc_ff;
   bswq_pkg::upc_type  upc_in;
   bswq_pkg::ctrl_type word;
   logic               accept;

   // Output decode: the control word of the current step.
   always_comb begin
      word       = bswq_pkg::ucode_rom(upc_ff);
      accept     = word.take && req_valid;
      req_ready  = word.take;
      cmd.word   = word;
      cmd.accept = accept;
   end

   // Next step.
   always_comb begin
      upc_in = upc_ff;
      if (!flags.stall) begin
         case (word.seq)
            bswq_pkg::SEQ_JUMP: begin
               upc_in = word.target;
            end
            bswq_pkg::SEQ_DISPATCH: begin
               if (accept) begin
                  upc_in = bswq_pkg::dispatch(bswq_pkg::op_type'(req_op));
               end
            end
            bswq_pkg::SEQ_IF_FULL: begin
               upc_in = flags.full ? word.target : bswq_pkg::upc_type'(upc_ff + 5'd1);
            end
            bswq_pkg::SEQ_IF_EMPTY: begin
               upc_in = flags.empty ? word.target : bswq_pkg::upc_type'(upc_ff + 5'd1);
            end
            bswq_pkg::SEQ_LOOP: begin
               upc_in = flags.more ? upc_ff : word.target;
            end
            default: begin
               upc_in = bswq_pkg::U_FETCH;
            end
         endcase
      end
   end

   // Step counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= bswq_pkg::U_FETCH;
      end else begin
         upc_ff <= upc_in;
      end
   end

   // A request always leads away from the fetch step.
   a_accept_leaves_fetch: assert property (@(posedge clock) disable iff (reset)
      accept |=> upc_ff != bswq_pkg::U_FETCH)
      else $error("sequencer stayed in fetch after a request transaction");

   // A stalled step holds the step counter.
   a_stall_holds_step: assert property (@(posedge clock) disable iff (reset)
      flags.stall |=> $stable(upc_ff))
      else $error("step counter moved during an output stall");

endmodule

// ===== hw/rtl/bswq_dp.sv =====
// Stack datapath: height, walk index, accumulator, entry RAM, capacity register
// and the result register. Depends on bswq_pkg and bswq_ram.
`timescale 1ns / 1ps

module bswq_dp #(
   parameter int DEPTH      = bswq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bswq_pkg::DATA_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  bswq_pkg::cmd_type              cmd,
   output bswq_pkg::flags_type            flags,
   input  logic [bswq_pkg::WORD_W-1:0]    req_operand,
   input  logic                           csr_wr_en,
   input  logic [bswq_pkg::CAP_W-1:0]     csr_wr_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bswq_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bswq_pkg::WORD_W-1:0]    rsp_data,
   output logic [bswq_pkg::HEIGHT_W-1:0]  rsp_height,
   output logic                           rsp_full,
   output logic                           rsp_empty,
   output logic                           rsp_found,
   output logic                           rsp_last
);

   // Only the low word of an entry ever reaches a result, so entries keep that much.
   localparam int STORE_W = (DATA_WIDTH < bswq_pkg::WORD_W) ? DATA_WIDTH : bswq_pkg::WORD_W;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W   = (CNT_W > bswq_pkg::CAP_W) ? CNT_W : bswq_pkg::CAP_W;

   bswq_pkg::ctrl_type w;

   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic [STORE_W-1:0]        acc_ff, acc_in;
   logic [STORE_W-1:0]        operand_ff;
   logic                      found_ff, found_in;
   logic                      rvalid_ff, rvalid_in;
   logic [bswq_pkg::CAP_W-1:0] capacity_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [bswq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bswq_pkg::WORD_W-1:0]   rsp_data_ff;
   logic [bswq_pkg::HEIGHT_W-1:0] rsp_height_ff;
   logic                      rsp_full_ff, rsp_empty_ff, rsp_found_ff, rsp_last_ff;

   logic [CMP_W-1:0]          cap_ext, eff_cap;
   logic                      full, empty, more, stall, emit, load;
   logic                      rd_en, wr_en;
   logic [CNT_W-1:0]          top_idx, walk_addr;
   logic [ADDR_W-1:0]         rd_addr, wr_addr;
   logic [STORE_W-1:0]        rd_data;
   logic [bswq_pkg::WORD_W-1:0] data_sel;

   assign w = cmd.word;

   // Height flags against the capacity, which saturates at the depth.
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
      full    = CMP_W'(count_ff) >= eff_cap;
      empty   = count_ff == '0;
      more    = (w.dir == bswq_pkg::DIR_UP) ? (idx_ff != count_ff) : (idx_ff != '0);
   end

   // Emission and stall: a step that emits waits for a free result register.
   always_comb begin
      emit  = (w.emit == bswq_pkg::EMIT_ALWAYS) ||
              ((w.emit == bswq_pkg::EMIT_RVALID) && rvalid_ff);
      stall = emit && rsp_valid_ff && !rsp_ready;
      load  = emit && !stall;
   end

   always_comb begin
      flags.full  = full;
      flags.empty = empty;
      flags.more  = more;
      flags.stall = stall;
   end

   // RAM addressing: the top entry, or the walk position.
   always_comb begin
      top_idx   = count_ff - CNT_W'(1);
      walk_addr = (w.dir == bswq_pkg::DIR_UP) ? idx_ff : (idx_ff - CNT_W'(1));
      rd_en     = !stall && (w.rd_top || (w.walk && more));
      rd_addr   = w.rd_top ? top_idx[ADDR_W-1:0] : walk_addr[ADDR_W-1:0];
      wr_en     = w.wr_push;
      wr_addr   = count_ff[ADDR_W-1:0];
   end

   bswq_ram #(
      .WIDTH (STORE_W),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (operand_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Height, index, accumulator and search flag.
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      acc_in    = acc_ff;
      found_in  = found_ff;
      rvalid_in = rvalid_ff;
      if (cmd.accept) begin
         found_in = 1'b0;
      end
      if (!stall) begin
         rvalid_in = rd_en;
         case (w.cnt)
            bswq_pkg::CNT_INC: count_in = count_ff + CNT_W'(1);
            bswq_pkg::CNT_DEC: count_in = count_ff - CNT_W'(1);
            default:           count_in = count_ff;
         endcase
         case (w.idx)
            bswq_pkg::IDX_ZERO: idx_in = '0;
            bswq_pkg::IDX_TOP:  idx_in = count_ff;
            default: begin
               if (w.walk && more) begin
                  idx_in = (w.dir == bswq_pkg::DIR_UP) ? (idx_ff + CNT_W'(1))
                                                       : (idx_ff - CNT_W'(1));
               end
            end
         endcase
         case (w.acc)
            bswq_pkg::ACC_ZERO: acc_in = '0;
            bswq_pkg::ACC_ONE:  acc_in = STORE_W'(1);
            bswq_pkg::ACC_ADD: begin
               if (rvalid_ff) acc_in = acc_ff + rd_data;
            end
            bswq_pkg::ACC_MUL: begin
               if (rvalid_ff) acc_in = STORE_W'(acc_ff * rd_data);
            end
            bswq_pkg::ACC_CMP: begin
               if (rvalid_ff && (rd_data == operand_ff)) found_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         idx_ff      <= '0;
         rvalid_ff   <= 1'b0;
         capacity_ff <= bswq_pkg::CAP_RESET;
      end else begin
         count_ff  <= count_in;
         idx_ff    <= idx_in;
         rvalid_ff <= rvalid_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      found_ff <= found_in;
      if (cmd.accept) begin
         operand_ff <= req_operand[STORE_W-1:0];
      end
   end

   // Result register.
   always_comb begin
      case (w.dsel)
         bswq_pkg::DSEL_RDATA: data_sel = bswq_pkg::WORD_W'(rd_data);
         bswq_pkg::DSEL_ACC:   data_sel = bswq_pkg::WORD_W'(acc_ff);
         default:              data_sel = '0;
      endcase
      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= w.st;
         rsp_data_ff   <= data_sel;
         rsp_height_ff <= bswq_pkg::HEIGHT_W'(count_ff);
         rsp_full_ff   <= full;
         rsp_empty_ff  <= empty;
         rsp_found_ff  <= found_ff;
         rsp_last_ff   <= (w.last == bswq_pkg::LAST_ONE) || (idx_ff == '0);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_full   = rsp_full_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_last   = rsp_last_ff;

   // The height never passes the depth.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("stack height beyond depth");

   // A push is only written into a stack with room left.
   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !full)
      else $error("entry written into a full stack");

   // A stalled step changes neither the height nor the walk index.
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(count_ff) && $stable(idx_ff))
      else $error("datapath state changed during an output stall");

endmodule

// ===== hw/rtl/bounded_stack_with_queries_core.sv =====
// Top level of the bounded stack core: microcode sequencer plus datapath.
// Depends on bswq_pkg, bswq_seq, bswq_dp (and through it bswq_ram).
//
//   channel  direction  tdata / data            tuser / other
//   req_     in         operand[31:0]           op[2:0]
//   rsp_     out        data, height, flags     status[1:0], tlast on final item
//   csr_     in         capacity[4:0]           write enable, no read-back
//
// Sum, product and contains walk the entry RAM upward from the bottom and dump walks
// it down from the top, one registered read a cycle unless the output stalls; dump
// gives one result per cycle while the output drains.
// Reset is synchronous and clears height, walk index, capacity (to 16), sequencer
// and result valid; no clearing pass is needed. A stalled result freezes the sequencer.
`timescale 1ns / 1ps

module bounded_stack_with_queries_core #(
   parameter int DEPTH      = bswq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bswq_pkg::DATA_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: operand[31:0]
   input  logic [bswq_pkg::WORD_W-1:0]       req_tdata,
   // tuser: op[2:0]
   input  logic [bswq_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: data[31:0], height[36:32], is_full[37], is_empty[38], found[39]
   output logic [bswq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // tuser: status[1:0]
   output logic [bswq_pkg::STATUS_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [bswq_pkg::CAP_W-1:0]        csr_wr_data
);

   bswq_pkg::cmd_type   cmd;
   bswq_pkg::flags_type flags;

   logic [bswq_pkg::WORD_W-1:0]   data;
   logic [bswq_pkg::HEIGHT_W-1:0] height;
   logic                          is_full, is_empty, found;

   // Sequencer.
   bswq_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_op    (req_tuser),
      .req_ready (req_tready),
      .flags     (flags),
      .cmd       (cmd)
   );

   // Datapath.
   bswq_dp #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .flags       (flags),
      .req_operand (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_status  (rsp_tuser),
      .rsp_data    (data),
      .rsp_height  (height),
      .rsp_full    (is_full),
      .rsp_empty   (is_empty),
      .rsp_found   (found),
      .rsp_last    (rsp_tlast)
   );

   // Pack the result fields, data in the lowest bits and found in the highest.
   assign rsp_tdata = {found, is_empty, is_full, height, data};

endmodule

// ===== sim/tb_bounded_stack_with_queries_core.sv =====
// Self-checking testbench for bounded_stack_with_queries_core: a table of directed
// requests, then random push-heavy and pop-heavy phases, all checked by a shadow stack.
// Depends on bswq_pkg and the RTL of the core only.
`timescale 1ns / 1ps

module tb_bounded_stack_with_queries_core;

   localparam int STACK_DEPTH     = bswq_pkg::DEPTH_DEF;
   localparam int MAX_REPORTS     = 10;
   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int NUM_DIR_ROWS    = 27;
   localparam int DRAIN_LIMIT     = 5000;

   // One result transaction, with the fields of the result channel.
   typedef struct packed {
      bswq_pkg::status_type status;
      logic [31:0]          data;
      logic [4:0]           height;
      logic                 is_full;
      logic                 is_empty;
      logic                 found;
      logic                 last;
   } stack_reply_type;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_TYPED, ROW_CAPACITY} row_kind_type;

   // A directed row: a request, or a capacity write held in value.
   typedef struct packed {
      row_kind_type         kind;
      bswq_pkg::op_type     op;
      logic [31:0]          value;
      bswq_pkg::status_type status;
      logic [31:0]          data;
      logic [4:0]           height;
      logic                 is_full;
      logic                 is_empty;
   } stim_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bswq_pkg::WORD_W-1:0]       req_tdata = '0;
   logic [bswq_pkg::OP_W-1:0]         req_tuser = bswq_pkg::OP_PUSH;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bswq_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic [bswq_pkg::STATUS_W-1:0]     rsp_tuser;
   logic                              rsp_tlast;
   logic                              csr_wr_en = 1'b0;
   logic [bswq_pkg::CAP_W-1:0]        csr_wr_data = '0;

   // Shadow copy of the stack and its capacity register.
   logic [31:0]  shadow_entries [0:STACK_DEPTH-1];
   int unsigned  shadow_height = 0;
   logic [4:0]   shadow_capacity = bswq_pkg::CAP_RESET;

   stack_reply_type replies_due [$];
   int unsigned  mismatches = 0;
   bit           no_idle = 1'b0;
   int unsigned  ready_stall_left = 0;

   // Capacity and share of pushes for each random phase.
   logic [4:0]   phase_caps [0:NUM_PHASES-1] = '{5'd31, 5'd16, 5'd1, 5'd15, 5'd0,
                                                 5'd16, 5'd6, 5'd20, 5'd16, 5'd12};
   int unsigned  phase_push_pct [0:NUM_PHASES-1] = '{75, 40, 60, 40, 70,
                                                     85, 30, 80, 40, 60};

   // Directed rows: empty cases, extreme operands, every operation, capacity writes, full cases.
   stim_row_type dir_rows [0:NUM_DIR_ROWS-1] = '{
      '{ROW_TYPED,    bswq_pkg::OP_POP,      32'h0,         bswq_pkg::ST_EMPTY,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_PEEK,     32'h0,         bswq_pkg::ST_EMPTY,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_SUM,      32'h0,         bswq_pkg::ST_EMPTY,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_PRODUCT,  32'h0,         bswq_pkg::ST_EMPTY,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_CONTAINS, 32'h0,         bswq_pkg::ST_EMPTY,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_DUMP,     32'h0,         bswq_pkg::ST_EMPTY,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_STATUS,   32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b1},
      '{ROW_TYPED,    bswq_pkg::OP_PUSH,     32'h7FFF_FFFF, bswq_pkg::ST_OK,
        32'h0, 5'd1, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_PUSH,     32'h8000_0000, bswq_pkg::ST_OK,
        32'h0, 5'd2, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_PUSH,     32'hFFFF_FFFF, bswq_pkg::ST_OK,
        32'h0, 5'd3, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_PUSH,     32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd4, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_PEEK,     32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd4, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_SUM,      32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_PRODUCT,  32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_CONTAINS, 32'h8000_0000, bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_CONTAINS, 32'h0000_0001, bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_DUMP,     32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_POP,      32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd3, 1'b0, 1'b0},
      '{ROW_CAPACITY, bswq_pkg::OP_PUSH,     32'd2,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_PUSH,     32'd5,         bswq_pkg::ST_FULL,
        32'h0, 5'd3, 1'b1, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_STATUS,   32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_CAPACITY, bswq_pkg::OP_PUSH,     32'd0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_POP,      32'h0,         bswq_pkg::ST_OK,
        32'hFFFF_FFFF, 5'd2, 1'b1, 1'b0},
      '{ROW_TYPED,    bswq_pkg::OP_PUSH,     32'd1,         bswq_pkg::ST_FULL,
        32'h0, 5'd2, 1'b1, 1'b0},
      '{ROW_CAPACITY, bswq_pkg::OP_PUSH,     32'd31,        bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_DUMP,     32'h0,         bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0},
      '{ROW_PREDICT,  bswq_pkg::OP_CONTAINS, 32'h7FFF_FFFF, bswq_pkg::ST_OK,
        32'h0, 5'd0, 1'b0, 1'b0}
   };

   bounded_stack_with_queries_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // A capacity above the depth behaves as the depth.
   function automatic int unsigned effective_capacity();
      return (shadow_capacity > STACK_DEPTH) ? STACK_DEPTH : shadow_capacity;
   endfunction

   // Queues one result, with height and flags taken from the shadow stack as it is now.
   task automatic queue_reply(input bswq_pkg::status_type st, input logic [31:0] data,
                              input logic found, input logic last);
      stack_reply_type r;
      r.status   = st;
      r.data     = data;
      r.height   = shadow_height[4:0];
      r.is_full  = (shadow_height >= effective_capacity());
      r.is_empty = (shadow_height == 0);
      r.found    = found;
      r.last     = last;
      replies_due.push_back(r);
   endtask

   // Applies one accepted request to the shadow stack and queues the results it causes.
   task automatic apply_stack_op(input bswq_pkg::op_type op, input logic [31:0] operand);
      logic [31:0] acc;
      logic        hit;
      int unsigned i;
      if (op == bswq_pkg::OP_PUSH) begin
         if (shadow_height >= effective_capacity()) begin
            queue_reply(bswq_pkg::ST_FULL, '0, 1'b0, 1'b1);
         end else begin
            shadow_entries[shadow_height] = operand;
            shadow_height++;
            queue_reply(bswq_pkg::ST_OK, '0, 1'b0, 1'b1);
         end
      end else if (op == bswq_pkg::OP_STATUS) begin
         queue_reply(bswq_pkg::ST_OK, '0, 1'b0, 1'b1);
      end else if (shadow_height == 0) begin
         queue_reply(bswq_pkg::ST_EMPTY, '0, 1'b0, 1'b1);
      end else begin
         case (op)
            bswq_pkg::OP_POP: begin
               shadow_height--;
               queue_reply(bswq_pkg::ST_OK, shadow_entries[shadow_height], 1'b0, 1'b1);
            end
            bswq_pkg::OP_PEEK: begin
               queue_reply(bswq_pkg::ST_OK, shadow_entries[shadow_height-1], 1'b0, 1'b1);
            end
            bswq_pkg::OP_SUM: begin
               acc = '0;
               for (i = 0; i < shadow_height; i++) acc = acc + shadow_entries[i];
               queue_reply(bswq_pkg::ST_OK, acc, 1'b0, 1'b1);
            end
            bswq_pkg::OP_PRODUCT: begin
               acc = 32'd1;
               for (i = 0; i < shadow_height; i++) acc = acc * shadow_entries[i];
               queue_reply(bswq_pkg::ST_OK, acc, 1'b0, 1'b1);
            end
            bswq_pkg::OP_CONTAINS: begin
               hit = 1'b0;
               for (i = 0; i < shadow_height; i++)
                  if (shadow_entries[i] == operand) hit = 1'b1;
               queue_reply(bswq_pkg::ST_OK, '0, hit, 1'b1);
            end
            default: begin
               // Dump runs from the top entry down to the bottom one.
               for (i = 0; i < shadow_height; i++)
                  queue_reply(bswq_pkg::ST_OK, shadow_entries[shadow_height-1-i], 1'b0,
                              (i + 1 == shadow_height));
            end
         endcase
      end
   endtask

   task automatic note_mismatch(input string what, input stack_reply_type want,
                                input stack_reply_type got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: expected st=%0d data=%h h=%0d full=%b empty=%b found=%b last=%b",
                  $time, what, want.status, want.data, want.height, want.is_full,
                  want.is_empty, want.found, want.last);
      if (mismatches <= MAX_REPORTS)
         $display("%0t %s: actual   st=%0d data=%h h=%0d full=%b empty=%b found=%b last=%b",
                  $time, what, got.status, got.data, got.height, got.is_full,
                  got.is_empty, got.found, got.last);
   endtask

   // Called at a falling edge; returns at the falling edge after the transaction.
   task automatic send_stack_op(input bswq_pkg::op_type op, input logic [31:0] value,
                                input bit typed, input stack_reply_type typed_reply);
      if (!no_idle && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 5)) @(negedge clock);
      req_tuser  = op;
      req_tdata  = value;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      apply_stack_op(op, value);
      // A typed row replaces the predicted result with the one written in the table.
      if (typed) replies_due[replies_due.size()-1] = typed_reply;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_replies_drained();
      while (replies_due.size() != 0) @(negedge clock);
   endtask

   // The register is only written once the core has gone quiet.
   task automatic write_capacity(input logic [4:0] value);
      wait_replies_drained();
      repeat (4) @(negedge clock);
      csr_wr_data = value;
      csr_wr_en   = 1'b1;
      @(negedge clock);
      csr_wr_en       = 1'b0;
      shadow_capacity = value;
   endtask

   // Mostly random operands, with extremes, small values that keep products alive,
   // and for contains often a value that is on the stack.
   function automatic logic [31:0] pick_operand(input bswq_pkg::op_type op);
      int unsigned sel;
      sel = $urandom_range(0, 7);
      if (op == bswq_pkg::OP_CONTAINS && shadow_height > 0 && sel < 4)
         return shadow_entries[$urandom_range(0, shadow_height - 1)];
      case (sel)
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         1, 2:    return $urandom_range(0, 6) - 3;
         default: return $urandom;
      endcase
   endfunction

   // Result side back-pressure in short random bursts.
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_tready = 1'b1;
      end else if (ready_stall_left > 0) begin
         rsp_tready = 1'b0;
         ready_stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_tready       = 1'b0;
         ready_stall_left = $urandom_range(0, 4);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   // Compare each result transaction with the oldest one due.
   always @(posedge clock) begin : check_replies
      stack_reply_type got;
      stack_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status   = bswq_pkg::status_type'(rsp_tuser);
         got.data     = rsp_tdata[31:0];
         got.height   = rsp_tdata[36:32];
         got.is_full  = rsp_tdata[37];
         got.is_empty = rsp_tdata[38];
         got.found    = rsp_tdata[39];
         got.last     = rsp_tlast;
         if (replies_due.size() == 0) begin
            note_mismatch("result with none due", '0, got);
         end else begin
            want = replies_due.pop_front();
            if (got !== want) note_mismatch("result differs", want, got);
         end
      end
   end

   // Guard against a hung core.
   initial begin
      #5ms;
      $display("FAIL bounded_stack_with_queries_core");
      $finish;
   end

   initial begin
      int               phase;
      int               n;
      int               waited;
      bswq_pkg::op_type op;
      stim_row_type     row;
      stack_reply_type  typed_reply;

      repeat (3) @(negedge clock);
      reset = 1'b0;

      // Directed part.
      for (n = 0; n < NUM_DIR_ROWS; n++) begin
         row = dir_rows[n];
         if (row.kind == ROW_CAPACITY) begin
            write_capacity(row.value[4:0]);
         end else begin
            typed_reply = '{row.status, row.data, row.height, row.is_full, row.is_empty,
                            1'b0, 1'b1};
            send_stack_op(row.op, row.value, row.kind == ROW_TYPED, typed_reply);
         end
      end

      // Random phases, each mainly filling or mainly draining the stack.
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         write_capacity(phase_caps[phase]);
         no_idle = (phase == NUM_PHASES - 1);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Once, hold the requests back until every result is in.
            if (phase == 3 && n == 10) wait_replies_drained();
            if ($urandom_range(0, 99) < phase_push_pct[phase])
               op = bswq_pkg::OP_PUSH;
            else
               op = bswq_pkg::op_type'($urandom_range(1, 7));
            send_stack_op(op, pick_operand(op), 1'b0, '0);
         end
      end

      waited = 0;
      while (replies_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (replies_due.size() != 0) begin
         $display("%0t %0d results never arrived", $time, replies_due.size());
         mismatches += replies_due.size();
      end
      repeat (20) @(negedge clock);

      if (mismatches == 0) begin
         $display("PASS bounded_stack_with_queries_core");
      end else begin
         $display("FAIL bounded_stack_with_queries_core");
      end
      $finish;
   end

endmodule

// ===== bounded_stack_with_queries_core.f =====
hw/rtl/bswq_pkg.sv
hw/rtl/bswq_ram.sv
hw/rtl/bswq_seq.sv
hw/rtl/bswq_dp.sv
hw/rtl/bounded_stack_with_queries_core.sv
sim/tb_bounded_stack_with_queries_core.sv
